### hw/rtl/rlwm_pkg.sv
// Package: constants, types and helpers shared by the window median block.
`timescale 1ns / 1ps
`default_nettype none
package rlwm_pkg;
  localparam int WinDepth   = 64;
  localparam int SrcCount   = 16;
  localparam int PtrW       = $clog2(WinDepth);
  localparam int CntW       = $clog2(WinDepth + 1);
  localparam int SrcW       = $clog2(SrcCount);
  localparam int ValW       = 32;
  localparam int TimeW      = 64;
  localparam int CfgIdxW    = 2;

  localparam logic [31:0] WinLenRst = 32'd60000000;
  localparam logic [31:0] MinValRst = 32'd0;
  localparam logic [31:0] MaxValRst = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_MIN_VALUE     = 2'd1,
    CFG_MAX_VALUE     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_RANGE     = 2'd1,
    ST_TOO_SOON  = 2'd2
  } status_t;

  // Result item handed from the sequencer to the output register.
  typedef struct packed {
    logic [1:0]      status;
    logic [ValW-1:0] median_value;
    logic [6:0]      live_count;
    logic            dropped_oldest;
  } result_t;
endpackage : rlwm_pkg
`default_nettype wire

### hw/rtl/rlwm_engine.sv
// Sequencer with a shared compare unit: eviction compaction and rank select.
`timescale 1ns / 1ps
`default_nettype none
module rlwm_engine (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire  [rlwm_pkg::SrcW-1:0] src,
  input  wire  [rlwm_pkg::ValW-1:0] val,
  input  wire  [rlwm_pkg::TimeW-1:0] now,
  input  wire  [31:0]               win_len,
  input  wire  [31:0]               min_val,
  input  wire  [31:0]               max_val,
  output logic                      busy,
  output logic                      done,
  output rlwm_pkg::result_t         result
);
  import rlwm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_CRD    = 9'b000000100,
    S_CWR    = 9'b000001000,
    S_INS    = 9'b000010000,
    S_OUTER  = 9'b000100000,
    S_INNER  = 9'b001000000,
    S_RANK   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // sample memories (one write, one registered read port each)
  logic [ValW-1:0]  val_mem [WinDepth];
  logic [TimeW-1:0] tim_mem [WinDepth];
  logic [TimeW-1:0] src_mem [SrcCount];
  logic [SrcCount-1:0] seen_r;

  logic [CntW-1:0] cnt_r;          // live samples, packed low
  logic [PtrW-1:0] rd_r, wr_r;     // compaction pointers
  logic [CntW-1:0] i_r, j_r, w_r;
  logic [CntW-1:0] rank_r;
  logic            first_r, drop_r, pass2_r;
  logic [ValW-1:0] rv_r, cand_r;
  logic [TimeW-1:0] rt_r, last_r;
  logic [SrcW-1:0] src_r;
  logic [ValW-1:0] val_r;
  logic [TimeW-1:0] now_r;
  logic            rd_en;
  logic [PtrW-1:0] rd_addr;
  logic            wr_en;
  logic [PtrW-1:0] wr_addr;
  logic [ValW-1:0] wr_val;
  logic [TimeW-1:0] wr_tim;
  result_t         res_r;
  logic            evict;
  logic [TimeW:0]  age;
  logic            hit;            // sample j ranks below the candidate
  logic [CntW-1:0] rank_fin;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rv_r <= val_mem[rd_addr];
      rt_r <= tim_mem[rd_addr];
    end
    if (wr_en) begin
      val_mem[wr_addr] <= wr_val;
      tim_mem[wr_addr] <= wr_tim;
    end
    // look up the incoming source while idle so the check sees its own entry
    last_r <= src_mem[(state_r == S_IDLE) ? src : src_r];
    if (state_r == S_INS) src_mem[src_r] <= now_r;
  end

  assign age   = {1'b0, now_r} - {1'b0, rt_r};
  assign evict = !pass2_r && (now_r > rt_r) && (age[TimeW-1:0] > {32'd0, win_len});

  assign hit      = (rv_r < cand_r) || (rv_r == cand_r && j_r < i_r);
  assign rank_fin = rank_r + {{(CntW-1){1'b0}}, hit};

  always_comb begin
    state_nxt = state_r;
    rd_en = 1'b0;
    rd_addr = rd_r;
    wr_en = 1'b0;
    wr_addr = wr_r;
    wr_val = rv_r;
    wr_tim = rt_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_CHECK;
      S_CHECK: begin
        if (val_r < min_val || val_r > max_val) state_nxt = S_DONE;
        else if (seen_r[src_r] && (now_r < last_r ||
                 now_r - last_r < {32'd0, win_len})) state_nxt = S_DONE;
        else if (cnt_r == '0) state_nxt = S_INS;
        else begin
          rd_en = 1'b1; rd_addr = '0; state_nxt = S_CRD;
        end
      end
      S_CRD: state_nxt = S_CWR;
      S_CWR: begin
        wr_en = !(evict || (pass2_r && first_r));
        if (i_r + 1'b1 < cnt_r) begin
          rd_en = 1'b1; rd_addr = PtrW'(i_r + 1'b1); state_nxt = S_CRD;
        end else state_nxt = S_INS;
      end
      S_INS: begin
        if (!pass2_r && w_r == CntW'(WinDepth)) begin
          rd_en = 1'b1; rd_addr = '0; state_nxt = S_CRD;
        end else begin
          wr_en = 1'b1; wr_addr = PtrW'(w_r); wr_val = val_r; wr_tim = now_r;
          state_nxt = S_OUTER;
        end
      end
      S_OUTER: begin
        rd_en = 1'b1; rd_addr = PtrW'(i_r); state_nxt = S_INNER;
      end
      S_INNER: begin
        rd_en = 1'b1; rd_addr = PtrW'(j_r); state_nxt = S_RANK;
      end
      S_RANK: begin
        if (j_r + 1'b1 < cnt_r) begin
          rd_en = 1'b1; rd_addr = PtrW'(j_r + 1'b1);
        end else if (rank_fin == CntW'(cnt_r >> 1))
          state_nxt = S_DONE;
        else state_nxt = S_OUTER;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      seen_r  <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (start) begin
          src_r <= src; val_r <= val; now_r <= now;
          res_r <= '0; pass2_r <= 1'b0;
        end
        S_CHECK: begin
          i_r <= '0; w_r <= '0; rd_r <= '0; wr_r <= '0; first_r <= 1'b1;
          res_r.live_count <= 7'(cnt_r);
          if (val_r < min_val || val_r > max_val) res_r.status <= ST_RANGE;
          else if (seen_r[src_r] && (now_r < last_r ||
                   now_r - last_r < {32'd0, win_len})) res_r.status <= ST_TOO_SOON;
          else seen_r[src_r] <= 1'b1;
        end
        S_CWR: begin
          if (pass2_r && first_r) first_r <= 1'b0;
          else if (!evict) begin
            w_r <= w_r + 1'b1; wr_r <= wr_r + 1'b1;
          end
          i_r <= i_r + 1'b1;
        end
        S_INS: begin
          if (!pass2_r && w_r == CntW'(WinDepth)) begin
            pass2_r <= 1'b1; i_r <= '0; w_r <= '0; wr_r <= '0; first_r <= 1'b1;
            res_r.dropped_oldest <= 1'b1;
          end else begin
            cnt_r <= w_r + 1'b1;
            res_r.live_count <= 7'(w_r + 1'b1);
            i_r <= '0;
          end
        end
        S_OUTER: begin j_r <= '0; rank_r <= '0; end
        S_INNER: cand_r <= rv_r;
        S_RANK: begin
          if (hit) rank_r <= rank_r + 1'b1;
          if (j_r + 1'b1 < cnt_r) j_r <= j_r + 1'b1;
          else if (rank_fin == CntW'(cnt_r >> 1))
            res_r.median_value <= cand_r;
          else i_r <= i_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign busy   = (state_r != S_IDLE);
  assign done   = (state_r == S_DONE);
  assign result = res_r;

  ap_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(WinDepth)) else $error("live count above depth");
  ap_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == S_IDLE) else $error("done not followed by idle");
  ap_rej: assert property (@(posedge clk) disable iff (!rst_n)
    done && res_r.status != ST_ACCEPTED |-> res_r.median_value == '0)
    else $error("rejected item carries a median");
endmodule
`default_nettype wire

### hw/rtl/rate_limited_window_median.sv
// Top level: stream ports, configuration registers and result register.
`timescale 1ns / 1ps
`default_nettype none
// Sliding time-window median with per-source rate limiting. Each input
// transaction is range checked, rate checked per source, then the store of up
// to 64 samples is compacted (expired samples evicted, oldest dropped when
// full), the new sample appended, and the upper median found by ranking every
// sample against every other on one shared comparator. An item's time grows with
// the samples held: compaction reads each in turn (a second pass when full) and
// ranking reads them in pairs, all through the single read port of the sample
// memory. A rejected item skips both and goes from the check straight to done.
// The input is not ready while an item is worked on, nor while a finished result
// waits unaccepted in the output register.
module rate_limited_window_median (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [103:0] in_tdata,  // source_id[3:0], sample_value[35:4], now_time[99:36]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata,  // status[1:0], median_value[33:2], live_count[40:34],
                                  // dropped_oldest[41]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [rlwm_pkg::CfgIdxW-1:0] cfg_index,
  input  wire  [31:0] cfg_data
);
  import rlwm_pkg::*;

  logic [31:0] win_len_r, min_val_r, max_val_r;
  logic        busy, done, out_valid_r, start;
  result_t     res, out_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= WinLenRst;
      min_val_r <= MinValRst;
      max_val_r <= MaxValRst;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WINDOW_LENGTH: win_len_r <= cfg_data;
        CFG_MIN_VALUE:     min_val_r <= cfg_data;
        CFG_MAX_VALUE:     max_val_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // engine idle and result slot free or being emptied
  assign in_tready = !busy && !(out_valid_r && !out_tready);
  assign start     = in_tvalid && in_tready;

  rlwm_engine u_engine (
    .clk, .rst_n, .start,
    .src(in_tdata[3:0]), .val(in_tdata[35:4]), .now(in_tdata[99:36]),
    .win_len(win_len_r), .min_val(min_val_r), .max_val(max_val_r),
    .busy, .done, .result(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (done) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
    if (done) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.dropped_oldest, out_r.live_count,
                       out_r.median_value, out_r.status};

  // a result never overwrites one still waiting
  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !done) else $error("result overwritten");
  ap_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy) else $error("engine did not start");
  ap_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.status != 2'd3) else $error("bad status");
endmodule
`default_nettype wire

### tb/sv/rate_limited_window_median_test.sv
// Testbench for the sliding time-window median block with per-source rate limiting.
`timescale 1ns / 1ps
module rate_limited_window_median_test;
  import rlwm_pkg::*;

  // Clock, reset and DUT ports
  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;   // source_id[3:0], sample_value[35:4], now_time[99:36]
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;  // status[1:0], median_value[33:2], live_count[40:34],
                            // dropped_oldest[41]
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  rate_limited_window_median dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  typedef struct {
    logic [31:0] val;
    logic [63:0] stamp;
  } held_sample_t;

  // Shadow copy of the block's state and registers
  logic [31:0]  win_len;
  logic [31:0]  lo_bound;
  logic [31:0]  hi_bound;
  held_sample_t held_q[$];       // oldest first
  logic [63:0]  last_push [SrcCount];
  logic         seen      [SrcCount];

  result_t      median_q[$];     // expected results, oldest first
  int unsigned  err_cnt;
  bit           idle_en;
  logic [63:0]  cur_time;

  // Upper median: sorted index n/2 of the held values
  function automatic logic [31:0] upper_median();
    logic [31:0] vals[];
    vals = new[held_q.size()];
    foreach (held_q[i]) vals[i] = held_q[i].val;
    vals.sort();
    return vals[vals.size() / 2];
  endfunction

  // Work out the result of one accepted transaction and update the shadow state
  function automatic result_t predict_median(logic [3:0] src, logic [31:0] val,
                                             logic [63:0] now);
    result_t r;
    int      k;
    r = '0;
    r.live_count = 7'(held_q.size());
    // range check first, then the rate check
    if (val < lo_bound || val > hi_bound) begin
      r.status = ST_RANGE;
      return r;
    end
    if (seen[src] && (now < last_push[src] || now - last_push[src] < {32'd0, win_len})) begin
      r.status = ST_TOO_SOON;
      return r;
    end
    last_push[src] = now;
    seen[src]      = 1'b1;
    // evict expired samples; a sample stamped after now is never expired
    k = 0;
    while (k < held_q.size()) begin
      if (now > held_q[k].stamp && now - held_q[k].stamp > {32'd0, win_len})
        held_q.delete(k);
      else
        k++;
    end
    if (held_q.size() >= WinDepth) begin
      void'(held_q.pop_front());
      r.dropped_oldest = 1'b1;
    end
    held_q.push_back('{val: val, stamp: now});
    r.status       = ST_ACCEPTED;
    r.median_value = upper_median();
    r.live_count   = 7'(held_q.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Result checker: sample at the rising edge
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (median_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_tdata), 64'd0);
      end else begin
        want = median_q.pop_front();
        if (out_tdata[1:0] !== want.status)
          report_mismatch("status", 64'(out_tdata[1:0]), 64'(want.status));
        if (out_tdata[33:2] !== want.median_value)
          report_mismatch("median_value", 64'(out_tdata[33:2]), 64'(want.median_value));
        if (out_tdata[40:34] !== want.live_count)
          report_mismatch("live_count", 64'(out_tdata[40:34]), 64'(want.live_count));
        if (out_tdata[41] !== want.dropped_oldest)
          report_mismatch("dropped_oldest", 64'(out_tdata[41]), 64'(want.dropped_oldest));
      end
    end
  end

  // Receiver back-pressure in bursts, driven at the falling edge
  always @(negedge clk) begin
    int run;
    if (!rst_n) begin
      out_tready = 1'b1;
      run        = 0;
    end else if (run > 0 && idle_en) begin
      run--;
    end else if (idle_en && $urandom_range(0, 2) == 0) begin
      out_tready = 1'b0;
      run        = $urandom_range(0, 13);
    end else begin
      out_tready = 1'b1;
      run        = $urandom_range(0, 40);
    end
  end

  // Register write, only ever issued while the block is idle
  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WINDOW_LENGTH: win_len  = value;
      CFG_MIN_VALUE:     lo_bound = value;
      CFG_MAX_VALUE:     hi_bound = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold off until every expected result has been seen
  task automatic wait_drain();
    while (median_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] wl, logic [31:0] lo, logic [31:0] hi);
    wait_drain();
    write_reg(CFG_WINDOW_LENGTH, wl);
    write_reg(CFG_MIN_VALUE, lo);
    write_reg(CFG_MAX_VALUE, hi);
  endtask

  // Send one sample; prediction happens at the accepting edge
  task automatic send_sample(logic [3:0] src, logic [31:0] val, logic [63:0] now);
    if (idle_en && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 14)) @(negedge clk);
    else
      @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {4'd0, now, val, src};
    do @(posedge clk); while (!in_tready);
    median_q.push_back(predict_median(src, val, now));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Defaults, extremes of the fields, check order and time going backwards
  task automatic test_directed();
    send_sample(4'd0, 32'd0, 64'd0);
    send_sample(4'd15, 32'hFFFF_FFFF, 64'd10);
    send_sample(4'd0, 32'd5, 64'd20);          // same source too soon
    send_sample(4'd15, 32'd7, 64'd5);          // time went backwards
    send_sample(4'd3, 32'h8000_0000, 64'd30);
    set_regs(32'd60000000, 32'd100, 32'd200);
    send_sample(4'd4, 32'd99, 64'd40);
    send_sample(4'd5, 32'd201, 64'd40);
    send_sample(4'd6, 32'd100, 64'd41);
    send_sample(4'd7, 32'd200, 64'd42);
    send_sample(4'd0, 32'd50, 64'd43);         // range beats rate
    send_sample(4'd0, 32'd150, 64'd44);        // too soon, value fine
    set_regs(32'd60000000, 32'd300, 32'd299);  // empty range
    send_sample(4'd8, 32'd300, 64'd50);
    send_sample(4'd9, 32'd299, 64'd50);
    send_sample(4'd10, 32'hFFFF_FFFF, 64'd50);
  endtask

  // Zero window: no spacing limit, so the store fills and drops its oldest
  task automatic test_full_store();
    set_regs(32'd0, 32'd0, 32'hFFFF_FFFF);
    for (int i = 0; i < 70; i++)
      send_sample(4'($urandom), $urandom, 64'd1000);
    // one tick later everything held is strictly older and goes
    send_sample(4'd1, 32'd77, 64'd1001);
    cur_time = 64'd2000;
  endtask

  // Random sweep under one register setting
  task automatic test_random(int cnt, logic [31:0] wl, logic [31:0] lo, logic [31:0] hi);
    int          pick;
    logic [31:0] val;
    logic [63:0] step;
    set_regs(wl, lo, hi);
    step = {32'd0, wl} / 8 + 1;
    if (step > 64'd100000) step = 64'd100000;
    for (int i = 0; i < cnt; i++) begin
      pick = $urandom_range(0, 99);
      val  = (hi >= lo) ? lo + $urandom % (hi - lo + 1) : $urandom;
      if (hi == 32'hFFFF_FFFF && lo == 32'd0) val = $urandom;
      cur_time += $urandom_range(0, 32'(step));
      if (pick < 85)
        send_sample(4'($urandom), val, cur_time);
      else if (pick < 95)
        send_sample(4'($urandom), $urandom, cur_time);
      else
        send_sample(4'($urandom), val, cur_time - $urandom_range(0, 32'(step)));
    end
  endtask

  // Times near the top of the 64-bit range: comparisons must not wrap
  task automatic test_wide_time();
    set_regs(32'd10, 32'd0, 32'hFFFF_FFFF);
    send_sample(4'd11, 32'd1, 64'hFFFF_FFFF_FFFF_FFF0);
    send_sample(4'd12, 32'd2, 64'hFFFF_FFFF_FFFF_FFFA);
    send_sample(4'd13, 32'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(4'd12, 32'd4, 64'hFFFF_FFFF_FFFF_FFFF);  // 5 ticks on, too soon
    send_sample(4'd11, 32'd5, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WINDOW_LENGTH;
    cfg_data  = '0;
    err_cnt   = 0;
    idle_en   = 1'b1;
    cur_time  = '0;
    win_len   = WinLenRst;
    lo_bound  = MinValRst;
    hi_bound  = MaxValRst;
    for (int s = 0; s < SrcCount; s++) begin
      seen[s]      = 1'b0;
      last_push[s] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_store();
    test_random(300, 32'd1000, 32'd0, 32'hFFFF_FFFF);
    test_random(250, 32'd200, 32'd1000, 32'd5000);
    test_random(120, 32'd0, 32'd0, 32'hFFFF_FFFF);
    test_random(80, 32'hFFFF_FFFF, 32'd10, 32'hFFFF_FFF0);
    idle_en = 1'b0;  // closing stretch runs flat out
    test_random(250, 32'd64, 32'd0, 32'hFFFF_FFFF);
    test_wide_time();

    while (median_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #400_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rlwm_pkg.sv
hw/rtl/rlwm_engine.sv
hw/rtl/rate_limited_window_median.sv
tb/sv/rate_limited_window_median_test.sv
